### hdl/zero_run_literal_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// zero-run literal decoder assertion macros
// shared concurrent checks, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_LITERAL_DECODER_CORE_ASSERT_SVH
`define ZERO_RUN_LITERAL_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define ZRLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("zrld check failed");

// next-cycle implication
`define ZRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("zrld check failed");

`endif

### hdl/zrld_pkg.sv
// ----------------------------------------------------------------------------
// zrld_pkg
// types and constants shared by the zero-run literal decoder modules
// ----------------------------------------------------------------------------
package zrld_pkg;

    // input request
    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_in_item;

    // decoded output byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       zero_fill;
        logic       last;
    } t_out_item;

    // command passed from classifier to emitter
    typedef struct packed {
        logic       is_run;
        logic [7:0] data;
        logic [5:0] run_m1;
    } t_cmd;

    // action codes
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // top two bits of a control byte
    localparam logic [1:0] CTL_ONE  = 2'b00;
    localparam logic [1:0] CTL_TWO  = 2'b01;
    localparam logic [1:0] CTL_FOUR = 2'b10;
    localparam logic [1:0] CTL_LONG = 2'b11;

    localparam logic [6:0] LIT_ONE  = 7'd1;
    localparam logic [6:0] LIT_TWO  = 7'd2;
    localparam logic [6:0] LIT_FOUR = 7'd4;

    localparam int QUEUE_DEPTH = 4;

endpackage

### hdl/zrld_front.sv
// ----------------------------------------------------------------------------
// zrld_front
// accepts stream requests, tracks literal and zero counts, queues commands
// ----------------------------------------------------------------------------
module zrld_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  zrld_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output zrld_pkg::t_cmd    o_q_cmd
);

    logic [6:0] r_lit;
    logic [6:0] n_lit;
    logic [6:0] r_zeros;
    logic [6:0] n_zeros;
    logic       accept;
    logic [6:0] run_len;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign run_len    = {1'b0, i_in_data.in_byte[5:0]} + 7'd1;

    always_comb begin
        n_lit          = r_lit;
        n_zeros        = r_zeros;
        o_q_push       = 1'b0;
        o_q_cmd.is_run = 1'b1;
        o_q_cmd.data   = i_in_data.in_byte;
        o_q_cmd.run_m1 = 6'(r_zeros - 7'd1);
        if (accept) begin
            if (i_in_data.action == zrld_pkg::ACT_DRAIN) begin
                // zeros follow the literals of a group, so wait for those
                if (r_lit == 7'd0 && r_zeros != 7'd0) begin
                    o_q_push = 1'b1;
                    n_zeros  = 7'd0;
                end
            end else if (r_lit != 7'd0) begin
                o_q_push       = 1'b1;
                o_q_cmd.is_run = 1'b0;
                n_lit          = r_lit - 7'd1;
            end else begin
                o_q_push = (r_zeros != 7'd0);
                case (i_in_data.in_byte[7:6])
                    zrld_pkg::CTL_LONG: begin
                        n_lit   = run_len;
                        n_zeros = 7'd0;
                    end
                    zrld_pkg::CTL_TWO: begin
                        n_lit   = zrld_pkg::LIT_TWO;
                        n_zeros = run_len;
                    end
                    zrld_pkg::CTL_FOUR: begin
                        n_lit   = zrld_pkg::LIT_FOUR;
                        n_zeros = run_len;
                    end
                    default: begin
                        n_lit   = zrld_pkg::LIT_ONE;
                        n_zeros = run_len;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit   <= 7'd0;
            r_zeros <= 7'd0;
        end else begin
            r_lit   <= n_lit;
            r_zeros <= n_zeros;
        end
    end

endmodule

### hdl/zrld_fifo.sv
// ----------------------------------------------------------------------------
// zrld_fifo
// short command queue between the classifier and the emitter
// ----------------------------------------------------------------------------
`include "zero_run_literal_decoder_core_assert.svh"

module zrld_fifo #(
    parameter int DEPTH = zrld_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  zrld_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output zrld_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    zrld_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `ZRLD_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `ZRLD_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `ZRLD_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)

endmodule

### hdl/zrld_back.sv
// ----------------------------------------------------------------------------
// zrld_back
// emits queued literal bytes and zero runs one per cycle when not stalled
// ----------------------------------------------------------------------------
`include "zero_run_literal_decoder_core_assert.svh"

module zrld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  zrld_pkg::t_cmd     i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output zrld_pkg::t_out_item o_out_data
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    zrld_pkg::t_out_item r_out;
    zrld_pkg::t_out_item n_out;
    logic [5:0]          r_left;
    logic [5:0]          n_left;
    logic                load;

    // output slot free for a new byte next cycle
    assign load    = !r_out_valid || i_out_ready;
    assign o_q_pop = (r_state == ST_IDLE) && load && !i_q_empty;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_left      = r_left;
        case (r_state)
            ST_RUN: begin
                if (load) begin
                    n_out_valid     = 1'b1;
                    n_out.out_byte  = 8'd0;
                    n_out.zero_fill = 1'b1;
                    n_out.last      = (r_left == 6'd1);
                    n_left          = r_left - 6'd1;
                    if (r_left == 6'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                if (o_q_pop) begin
                    n_out_valid = 1'b1;
                    if (i_q_cmd.is_run) begin
                        n_out.out_byte  = 8'd0;
                        n_out.zero_fill = 1'b1;
                        n_out.last      = (i_q_cmd.run_m1 == 6'd0);
                        n_left          = i_q_cmd.run_m1;
                        if (i_q_cmd.run_m1 != 6'd0) begin
                            n_state = ST_RUN;
                        end
                    end else begin
                        n_out.out_byte  = i_q_cmd.data;
                        n_out.zero_fill = 1'b0;
                        n_out.last      = 1'b1;
                    end
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out  <= n_out;
        r_left <= n_left;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ZRLD_ASSERT_SAME(a_run_has_output, i_clk, i_rst_n, r_state == ST_RUN, r_out_valid)
    `ZRLD_ASSERT_SAME(a_fill_is_zero, i_clk, i_rst_n, r_out_valid && r_out.zero_fill,
        r_out.out_byte == 8'd0)
    `ZRLD_ASSERT_SAME(a_literal_last, i_clk, i_rst_n, r_out_valid && !r_out.zero_fill,
        r_out.last)

endmodule

### hdl/zero_run_literal_decoder_core.sv
// ----------------------------------------------------------------------------
// zero_run_literal_decoder_core
// decodes control, literal and zero-run bytes into a plain byte stream
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry a request holding an action
// and a stream byte; action zero consumes the byte, action one drains the
// zero run still owed by the current group.
// output channel: o_out_valid / i_out_ready carry one decoded byte with a
// zero-fill flag and a last flag marking the final byte of its request.
// a request that produces bytes has its command written into the command
// queue, then popped by the emitter into the output register; requests are
// taken one per cycle while the four-entry command queue has room.
// a zero run of n bytes (1 to 64) occupies the emitter, one byte per cycle
// while the receiver is ready, and requests back up once the queue fills
// behind it. a stalled receiver holds the output register; the queue then
// fills and o_in_ready drops.
// reset clears the pending counts, the queue and the output valid flag; no
// clearing pass follows, the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module zero_run_literal_decoder_core #(
    parameter int QUEUE_DEPTH = zrld_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  zrld_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output zrld_pkg::t_out_item o_out_data
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    zrld_pkg::t_cmd q_wr_cmd;
    zrld_pkg::t_cmd q_rd_cmd;

    zrld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_wr_cmd)
    );

    zrld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_rd_cmd),
        .o_empty (q_empty)
    );

    zrld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_rd_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/tb_zero_run_literal_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zero_run_literal_decoder_core
// self-checking bench for the zero-run literal decoder core
// ----------------------------------------------------------------------------
// requests are sent through a valid/ready driver with random gaps; a monitor
// predicts the decoded bytes of each accepted request from its own copy of
// the pending literal and zero counts, and checks every accepted output byte
// against the oldest prediction. directed groups come first, then random
// well-formed groups mixed with drains and stray bytes.
// ----------------------------------------------------------------------------
module tb_zero_run_literal_decoder_core;

    localparam int TOTAL_REQUESTS = 430;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    zrld_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    zrld_pkg::t_out_item o_out_data;

    // predictor state
    logic [6:0]          pend_literals;
    logic [6:0]          pend_zeros;
    zrld_pkg::t_out_item decoded_bytes_due[$];
    zrld_pkg::t_out_item due;

    int tx_max_gap = 8;
    int rx_max_gap = 8;
    int n_sent     = 0;
    int n_accepted = 0;
    int n_drains   = 0;
    int n_results  = 0;
    int n_zero_out = 0;
    int fail_count = 0;
    int idle_count = 0;

    zero_run_literal_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void flush_zero_run();
        zrld_pkg::t_out_item z;
        while (pend_zeros != 7'd0) begin
            z.out_byte  = 8'h00;
            z.zero_fill = 1'b1;
            z.last      = (pend_zeros == 7'd1);
            decoded_bytes_due.push_back(z);
            pend_zeros = pend_zeros - 7'd1;
        end
    endfunction

    function automatic void decode_request(input zrld_pkg::t_in_item req);
        zrld_pkg::t_out_item lit;
        if (req.action == zrld_pkg::ACT_DRAIN) begin
            // zeros follow the literals of their group, so a drain waits
            if (pend_literals == 7'd0)
                flush_zero_run();
        end else if (pend_literals != 7'd0) begin
            lit.out_byte  = req.in_byte;
            lit.zero_fill = 1'b0;
            lit.last      = 1'b1;
            decoded_bytes_due.push_back(lit);
            pend_literals = pend_literals - 7'd1;
        end else begin
            flush_zero_run();
            case (req.in_byte[7:6])
                zrld_pkg::CTL_LONG: begin
                    pend_literals = {1'b0, req.in_byte[5:0]} + 7'd1;
                    pend_zeros    = 7'd0;
                end
                zrld_pkg::CTL_TWO: begin
                    pend_literals = zrld_pkg::LIT_TWO;
                    pend_zeros    = {1'b0, req.in_byte[5:0]} + 7'd1;
                end
                zrld_pkg::CTL_FOUR: begin
                    pend_literals = zrld_pkg::LIT_FOUR;
                    pend_zeros    = {1'b0, req.in_byte[5:0]} + 7'd1;
                end
                default: begin
                    pend_literals = zrld_pkg::LIT_ONE;
                    pend_zeros    = {1'b0, req.in_byte[5:0]} + 7'd1;
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pend_literals = 7'd0;
            pend_zeros    = 7'd0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_request(i_in_data);
                n_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (decoded_bytes_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected output byte %02h zero_fill %b last %b",
                                 o_out_data.out_byte, o_out_data.zero_fill,
                                 o_out_data.last);
                    fail_count++;
                end else begin
                    due = decoded_bytes_due.pop_front();
                    if (due.zero_fill)
                        n_zero_out++;
                    if (o_out_data.out_byte !== due.out_byte ||
                        o_out_data.zero_fill !== due.zero_fill ||
                        o_out_data.last !== due.last) begin
                        if (fail_count < 10)
                            $display({"mismatch at output %0d: ",
                                      "expected %02h/%b/%b got %02h/%b/%b"},
                                     n_results, due.out_byte, due.zero_fill, due.last,
                                     o_out_data.out_byte, o_out_data.zero_fill,
                                     o_out_data.last);
                        fail_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count == WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d bytes outstanding",
                         decoded_bytes_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall before each byte
    // ------------------------------------------------------------------------
    initial begin : receiver
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    task automatic send_request(input logic act, input logic [7:0] data);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_data.action  <= act;
        i_in_data.in_byte <= data;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        n_sent++;
        if (act == zrld_pkg::ACT_DRAIN)
            n_drains++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    // control byte followed by its literals, with the odd drain thrown in
    task automatic send_random_group();
        logic [1:0] top;
        logic [5:0] low;
        int         n_lits;
        int         k;
        top = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            low = 6'($urandom_range(0, 63));
        else
            low = 6'($urandom_range(0, 5));
        case (top)
            zrld_pkg::CTL_ONE:  n_lits = 1;
            zrld_pkg::CTL_TWO:  n_lits = 2;
            zrld_pkg::CTL_FOUR: n_lits = 4;
            default:            n_lits = int'(low) + 1;
        endcase
        send_request(zrld_pkg::ACT_BYTE, {top, low});
        for (k = 0; k < n_lits; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_request(zrld_pkg::ACT_DRAIN, 8'($urandom_range(0, 255)));
            send_request(zrld_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
            send_request(zrld_pkg::ACT_DRAIN, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_drain();
        send_request(zrld_pkg::ACT_DRAIN, 8'h00);
        send_request(zrld_pkg::ACT_DRAIN, 8'hFF);
    endtask

    task automatic test_short_groups();
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_ONE, 6'd0});
        send_request(zrld_pkg::ACT_BYTE, 8'hFF);
        send_request(zrld_pkg::ACT_DRAIN, 8'h00);
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_FOUR, 6'd2});
        send_request(zrld_pkg::ACT_BYTE, 8'h55);
        send_request(zrld_pkg::ACT_BYTE, 8'hAA);
        send_request(zrld_pkg::ACT_BYTE, 8'h01);
        send_request(zrld_pkg::ACT_BYTE, 8'hFE);
        // long group start flushes the three zeros of the group before
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_LONG, 6'd0});
        send_request(zrld_pkg::ACT_BYTE, 8'h00);
        // no zeros pending here, so nothing comes out
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_LONG, 6'd1});
        send_request(zrld_pkg::ACT_BYTE, 8'h80);
        send_request(zrld_pkg::ACT_BYTE, 8'h7F);
    endtask

    task automatic test_long_runs();
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_TWO, 6'h3F});
        send_request(zrld_pkg::ACT_BYTE, 8'h00);
        // drain between literals is ignored
        send_request(zrld_pkg::ACT_DRAIN, 8'hFF);
        send_request(zrld_pkg::ACT_BYTE, 8'h3C);
        send_request(zrld_pkg::ACT_BYTE, {zrld_pkg::CTL_ONE, 6'h3F});
        send_request(zrld_pkg::ACT_BYTE, 8'hC3);
        send_request(zrld_pkg::ACT_DRAIN, 8'h00);
        send_request(zrld_pkg::ACT_DRAIN, 8'h00);
        wait_all_results();
    endtask

    task automatic test_pause_between_groups();
        int g;
        for (g = 0; g < 8; g++) begin
            send_random_group();
            wait_all_results();
        end
    endtask

    task automatic test_back_to_back();
        int target;
        tx_max_gap = 0;
        rx_max_gap = 0;
        target = n_sent + 40;
        while (n_sent < target)
            send_random_group();
        // full-rate sender against a stalling receiver fills the queue
        rx_max_gap = 8;
        target = n_sent + 40;
        while (n_sent < target)
            send_random_group();
        tx_max_gap = 8;
    endtask

    task automatic test_random_stream();
        while (n_sent < TOTAL_REQUESTS) begin
            if ($urandom_range(0, 9) == 0)
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else
                send_random_group();
        end
    endtask

    initial begin : main
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_drain();
        test_short_groups();
        test_long_runs();
        test_pause_between_groups();
        test_back_to_back();
        test_random_stream();

        // push out any zero run still owed at the end of the stream
        send_request(zrld_pkg::ACT_DRAIN, 8'h00);
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d requests (%0d drains), checked %0d output bytes",
                 n_accepted, n_drains, n_results);
        $display("%0d of them zero fill, mismatches: %0d", n_zero_out, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
